### rtl/core/header_length_xor_frame_receiver_top_defines.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef HEADER_LENGTH_XOR_FRAME_RECEIVER_TOP_DEFINES_SVH
`define HEADER_LENGTH_XOR_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HLXFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HLXFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hlxfr_pkg.sv
// Types and constants of the header/length/XOR frame receiver.
package hlxfr_pkg;

    localparam int unsigned FIXED_FIELD_BYTES = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER_BYTES  = 2'd0;
    localparam logic [1:0] CFG_HEADER_LENGTH = 2'd1;
    localparam logic [1:0] CFG_BUFFER_LIMIT  = 2'd2;

    localparam logic [15:0] BUFFER_LIMIT_RESET = 16'd256;

    // byte roles
    localparam logic [3:0] ROLE_DROPPED  = 4'd0;
    localparam logic [3:0] ROLE_HEADER   = 4'd1;
    localparam logic [3:0] ROLE_LEN_LO   = 4'd2;
    localparam logic [3:0] ROLE_LEN_HI   = 4'd3;
    localparam logic [3:0] ROLE_SEQUENCE = 4'd4;
    localparam logic [3:0] ROLE_VERSION  = 4'd5;
    localparam logic [3:0] ROLE_ID       = 4'd6;
    localparam logic [3:0] ROLE_PAYLOAD  = 4'd7;
    localparam logic [3:0] ROLE_CHECKSUM = 4'd8;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [3:0]  byte_role;
        logic        frame_aborted;
        logic        frame_end;
        logic        frame_good;
        logic [15:0] payload_length;
        logic [7:0]  sequence_number;
        logic [7:0]  protocol_version;
        logic [7:0]  packet_kind;
    } result_t;

endpackage

### rtl/core/hlxfr_cfg.sv
// Configuration registers of the frame receiver.
module hlxfr_cfg #(
    parameter int MAX_HEADER_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [63:0]                     cfg_data,
    output logic [MAX_HEADER_BYTES*8-1:0]   header_bytes,
    output logic [3:0]                      header_length,
    output logic [15:0]                     buffer_limit
);

    logic [MAX_HEADER_BYTES*8-1:0] header_reg;
    logic [3:0]                    hlen_reg;
    logic [15:0]                   limit_reg;
    logic                          wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            hlen_reg   <= '0;
            limit_reg  <= hlxfr_pkg::BUFFER_LIMIT_RESET;
        end
        else if (wr)
        begin
            case (cfg_index)
                hlxfr_pkg::CFG_HEADER_BYTES:  header_reg <= cfg_data[MAX_HEADER_BYTES*8-1:0];
                hlxfr_pkg::CFG_HEADER_LENGTH: hlen_reg   <= cfg_data[3:0];
                hlxfr_pkg::CFG_BUFFER_LIMIT:  limit_reg  <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    assign header_bytes  = header_reg;
    assign header_length = hlen_reg;
    assign buffer_limit  = limit_reg;

endmodule

### rtl/core/hlxfr_core.sv
// Frame state and per-byte step logic of the frame receiver.
module hlxfr_core #(
    parameter int MAX_HEADER_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [7:0]                      byte_in,
    input  logic [MAX_HEADER_BYTES*8-1:0]   header_bytes,
    input  logic [3:0]                      header_length,
    input  logic [15:0]                     buffer_limit,
    output hlxfr_pkg::result_t              result
);

    localparam int IDX_W = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;

    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  kind_reg, kind_next;

    logic [3:0]  hlen;
    logic [7:0]  hdr_sel;
    logic        mismatch;
    logic        keep;
    logic [15:0] eff_count;
    logic [15:0] eff_len;
    logic [7:0]  eff_xor;
    logic [15:0] hbase;
    logic [17:0] pay_end;
    hlxfr_pkg::result_t res;

    assign hlen = (header_length > 4'(MAX_HEADER_BYTES)) ? 4'(MAX_HEADER_BYTES) : header_length;

    always_comb
    begin
        hdr_sel = '0;
        for (int i = 0; i < MAX_HEADER_BYTES; i++)
        begin
            if (count_reg[IDX_W-1:0] == IDX_W'(i))
                hdr_sel = header_bytes[i*8 +: 8];
        end
    end

    assign mismatch  = (count_reg < 16'(hlen)) && (byte_in != hdr_sel);
    assign keep      = !mismatch || (byte_in == header_bytes[7:0]);
    assign eff_count = mismatch ? '0 : count_reg;
    assign eff_len   = mismatch ? '0 : len_reg;
    assign eff_xor   = mismatch ? '0 : xor_reg;
    assign hbase     = 16'(hlen);
    assign pay_end   = {2'b00, eff_len} + 18'(hlen) + 18'(hlxfr_pkg::FIXED_FIELD_BYTES);

    always_comb
    begin
        count_next = eff_count;
        len_next   = eff_len;
        xor_next   = eff_xor;
        seq_next   = seq_reg;
        ver_next   = ver_reg;
        kind_next  = kind_reg;
        res        = '0;
        res.data_byte     = byte_in;
        res.byte_role     = hlxfr_pkg::ROLE_DROPPED;
        res.frame_aborted = mismatch && (count_reg != '0);
        if (keep)
        begin
            if (eff_count < buffer_limit)
            begin
                count_next = eff_count + 16'd1;
                xor_next   = eff_xor ^ byte_in;
                if (eff_count < hbase)
                    res.byte_role = hlxfr_pkg::ROLE_HEADER;
                else if (eff_count == hbase)
                begin
                    res.byte_role = hlxfr_pkg::ROLE_LEN_LO;
                    len_next      = {8'h00, byte_in};
                end
                else if (eff_count == hbase + 16'd1)
                begin
                    res.byte_role = hlxfr_pkg::ROLE_LEN_HI;
                    len_next      = {byte_in, eff_len[7:0]};
                end
                else if (eff_count == hbase + 16'd2)
                begin
                    res.byte_role = hlxfr_pkg::ROLE_SEQUENCE;
                    seq_next      = byte_in;
                end
                else if (eff_count == hbase + 16'd3)
                begin
                    res.byte_role = hlxfr_pkg::ROLE_VERSION;
                    ver_next      = byte_in;
                end
                else if (eff_count == hbase + 16'd4)
                begin
                    res.byte_role = hlxfr_pkg::ROLE_ID;
                    kind_next     = byte_in;
                end
                else if ({2'b00, eff_count} < pay_end)
                    res.byte_role = hlxfr_pkg::ROLE_PAYLOAD;
                else
                begin
                    res.byte_role        = hlxfr_pkg::ROLE_CHECKSUM;
                    res.frame_end        = 1'b1;
                    res.frame_good       = (byte_in == eff_xor);
                    res.payload_length   = eff_len;
                    res.sequence_number  = seq_reg;
                    res.protocol_version = ver_reg;
                    res.packet_kind      = kind_reg;
                    count_next           = '0;
                    len_next             = '0;
                    xor_next             = '0;
                end
            end
            else
            begin
                res.frame_aborted = 1'b1;
                count_next        = '0;
                len_next          = '0;
                xor_next          = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
            seq_reg   <= '0;
            ver_reg   <= '0;
            kind_reg  <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            seq_reg   <= seq_next;
            ver_reg   <= ver_next;
            kind_reg  <= kind_next;
        end
    end

    assign result = res;

endmodule

### rtl/core/header_length_xor_frame_receiver_top.sv
// Top level of the header/length/XOR frame receiver.
//
//   channel  valid      ready      payload
//   -------  ---------  ---------  ---------------------------------------------
//   in       in_valid   in_ready   byte_in
//   out      out_valid  out_ready  data_byte, byte_role, frame_aborted, ...
//   cfg      cfg_valid  cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready is high; a byte's result reaches the output
// after its transfer through the input register, then step logic into the result register.
// The frame state updates when a byte moves from the input to the result register.
// out_ready low holds the result register; the input register still takes one more byte.
// Reset clears frame state, valid flags and the configuration (buffer limit 256).
// cfg_ready is always high; writes go to the registers at once.
`include "header_length_xor_frame_receiver_top_defines.svh"

module header_length_xor_frame_receiver_top #(
    parameter int MAX_HEADER_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [3:0]  byte_role,
    output logic        frame_aborted,
    output logic        frame_end,
    output logic        frame_good,
    output logic [15:0] payload_length,
    output logic [7:0]  sequence_number,
    output logic [7:0]  protocol_version,
    output logic [7:0]  packet_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [MAX_HEADER_BYTES*8-1:0] header_bytes;
    logic [3:0]                    header_length;
    logic [15:0]                   buffer_limit;

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               out_valid_reg, out_valid_next;
    hlxfr_pkg::result_t res_reg;
    hlxfr_pkg::result_t step_res;
    logic               advance;
    logic               in_xfer;

    hlxfr_cfg #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .header_bytes  (header_bytes),
        .header_length (header_length),
        .buffer_limit  (buffer_limit)
    );

    hlxfr_core #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .byte_in       (s1_byte_reg),
        .header_bytes  (header_bytes),
        .header_length (header_length),
        .buffer_limit  (buffer_limit),
        .result        (step_res)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_byte_reg <= byte_in;
        if (advance)
            res_reg <= step_res;
    end

    assign out_valid        = out_valid_reg;
    assign data_byte        = res_reg.data_byte;
    assign byte_role        = res_reg.byte_role;
    assign frame_aborted    = res_reg.frame_aborted;
    assign frame_end        = res_reg.frame_end;
    assign frame_good       = res_reg.frame_good;
    assign payload_length   = res_reg.payload_length;
    assign sequence_number  = res_reg.sequence_number;
    assign protocol_version = res_reg.protocol_version;
    assign packet_kind      = res_reg.packet_kind;

    `HLXFR_ASSERT_NOW(a_end_is_checksum, out_valid_reg && res_reg.frame_end,
        res_reg.byte_role == hlxfr_pkg::ROLE_CHECKSUM, "frame end on non-checksum byte")
    `HLXFR_ASSERT_NOW(a_fields_zero, out_valid_reg && !res_reg.frame_end,
        !res_reg.frame_good && res_reg.payload_length == '0 && res_reg.packet_kind == '0,
        "frame fields set outside frame end")
    `HLXFR_ASSERT_NEXT(a_data_pass, advance, res_reg.data_byte == $past(s1_byte_reg),
        "result byte differs from stepped byte")
    `HLXFR_ASSERT_NEXT(a_no_loss, s1_valid_reg && out_valid_reg && !out_ready,
        s1_valid_reg && out_valid_reg, "pending byte or result lost under stall")

endmodule
